// ===== hdl/jhdp_pkg.sv =====
// shared types, constants and helpers for the jfif header dimension parser
package jhdp_pkg;

    localparam logic [31:0] SOI_APP0_WORD = 32'hE0FF_D8FF;
    localparam logic [31:0] JFIF_WORD     = 32'h4649_464A;
    localparam logic [7:0]  SOF0_ID       = 8'hC0;
    localparam logic [7:0]  MARK_BYTE     = 8'hFF;
    localparam logic [15:0] APP0_LEN_MIN  = 16'd6;
    localparam logic [15:0] SEG_LEN_MIN   = 16'd2;
    localparam logic [3:0]  HDR_LAST_IDX  = 4'd9;
    localparam logic [3:0]  HDR_LENHI_IDX = 4'd4;
    localparam logic [3:0]  HDR_LENLO_IDX = 4'd5;
    localparam logic [3:0]  HDR_JFIF_IDX  = 4'd6;
    localparam logic [3:0]  HDR_MAGIC_END = 4'd4;
    localparam logic [3:0]  FRM_HEIGHT_HI = 4'd3;
    localparam logic [3:0]  FRM_HEIGHT_LO = 4'd4;
    localparam logic [3:0]  FRM_WIDTH_HI  = 4'd5;
    localparam logic [3:0]  FRM_WIDTH_LO  = 4'd6;
    localparam logic        STATUS_OK     = 1'b0;
    localparam logic        STATUS_ERR    = 1'b1;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_SKIP   = 3'd1,
        PH_MARKER = 3'd2,
        PH_ID     = 3'd3,
        PH_LEN_HI = 3'd4,
        PH_LEN_LO = 3'd5,
        PH_FRAME  = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } beat_t;

    typedef struct packed {
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic        status;
    } result_t;

    // expected byte at a fixed header position, zero where none is checked
    function automatic logic [7:0] hdr_byte(input logic [3:0] k);
        logic [7:0] v;
        v = 8'h00;
        case (k)
            4'd0: v = SOI_APP0_WORD[7:0];
            4'd1: v = SOI_APP0_WORD[15:8];
            4'd2: v = SOI_APP0_WORD[23:16];
            4'd3: v = SOI_APP0_WORD[31:24];
            4'd6: v = JFIF_WORD[7:0];
            4'd7: v = JFIF_WORD[15:8];
            4'd8: v = JFIF_WORD[23:16];
            4'd9: v = JFIF_WORD[31:24];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/jhdp_in_reg.sv =====
// input register stage holding one byte beat ahead of the parser
module jhdp_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  jhdp_pkg::beat_t s_beat,
    input  logic           take,
    output logic           beat_valid,
    output jhdp_pkg::beat_t beat
);
    import jhdp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    assign s_tready   = !valid_reg || take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb begin
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg <= s_beat;
        end
    end

endmodule

// ===== hdl/jhdp_parser.sv =====
// marker segment walker: parse state and one-byte step logic
module jhdp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  jhdp_pkg::beat_t   beat,
    output logic              res_fire,
    output jhdp_pkg::result_t res
);
    import jhdp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [15:0] skip_remaining_reg, skip_remaining_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [3:0]  frame_index_reg, frame_index_next;
    logic [15:0] height_hold_reg, height_hold_next;
    logic [15:0] width_hold_reg, width_hold_next;
    logic        result_given_reg, result_given_next;

    logic [7:0]  b;
    logic        last;
    logic [15:0] seg_len;
    logic [15:0] skip_dec;
    logic        emit_ok;
    logic        emit_err;
    logic        emit_any;

    assign b        = beat.data_byte;
    assign last     = beat.last_byte;
    assign seg_len  = {length_high_reg, b};
    assign skip_dec = skip_remaining_reg - 16'd1;

    // result decision
    always_comb begin
        emit_ok  = 1'b0;
        emit_err = 1'b0;
        unique case (phase_reg)
            PH_MAGIC: begin
                if (header_index_reg < HDR_MAGIC_END) begin
                    emit_err = (b != hdr_byte(header_index_reg));
                end else if (header_index_reg == HDR_LENLO_IDX) begin
                    emit_err = (seg_len < APP0_LEN_MIN);
                end else if (header_index_reg >= HDR_JFIF_IDX &&
                             header_index_reg <= HDR_LAST_IDX) begin
                    emit_err = (b != hdr_byte(header_index_reg));
                end
            end
            PH_MARKER: emit_err = (b != MARK_BYTE);
            PH_LEN_LO: emit_err = (seg_len < SEG_LEN_MIN);
            PH_FRAME:  emit_ok  = (frame_index_reg == FRM_WIDTH_LO);
            default: begin
            end
        endcase
        // early end of file
        if (last && !emit_ok && !emit_err && !result_given_reg) begin
            emit_err = 1'b1;
        end
    end

    assign emit_any = emit_ok || emit_err;
    assign res_fire = step_en && emit_any;

    always_comb begin
        res.status       = emit_ok ? STATUS_OK : STATUS_ERR;
        res.image_width  = emit_ok ? {width_hold_reg[15:8], b} : 16'd0;
        res.image_height = emit_ok ? height_hold_reg : 16'd0;
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (last) begin
            phase_next = PH_MAGIC;
        end else if (emit_any) begin
            phase_next = PH_DONE;
        end else begin
            unique case (phase_reg)
                PH_MAGIC: begin
                    if (header_index_reg >= HDR_LAST_IDX) begin
                        phase_next = (skip_remaining_reg == 16'd0) ? PH_MARKER : PH_SKIP;
                    end
                end
                PH_SKIP:   if (skip_dec == 16'd0) phase_next = PH_MARKER;
                PH_MARKER: phase_next = PH_ID;
                PH_ID:     phase_next = (b == SOF0_ID) ? PH_FRAME : PH_LEN_HI;
                PH_LEN_HI: phase_next = PH_LEN_LO;
                PH_LEN_LO: phase_next = (seg_len == SEG_LEN_MIN) ? PH_MARKER : PH_SKIP;
                PH_FRAME:  phase_next = PH_FRAME;
                PH_DONE:   phase_next = PH_DONE;
            endcase
        end
    end

    // counters and held fields
    always_comb begin
        header_index_next   = header_index_reg;
        skip_remaining_next = skip_remaining_reg;
        length_high_next    = length_high_reg;
        frame_index_next    = frame_index_reg;
        height_hold_next    = height_hold_reg;
        width_hold_next     = width_hold_reg;
        result_given_next   = result_given_reg || emit_any;
        unique case (phase_reg)
            PH_MAGIC: begin
                if (header_index_reg == HDR_LENHI_IDX) begin
                    length_high_next = b;
                end
                if (header_index_reg == HDR_LENLO_IDX) begin
                    skip_remaining_next = seg_len - APP0_LEN_MIN;
                end
                if (!emit_err && header_index_reg < HDR_LAST_IDX) begin
                    header_index_next = header_index_reg + 4'd1;
                end
            end
            PH_SKIP:   skip_remaining_next = skip_dec;
            PH_ID:     if (b == SOF0_ID) frame_index_next = 4'd0;
            PH_LEN_HI: length_high_next = b;
            PH_LEN_LO: if (!emit_err) skip_remaining_next = seg_len - SEG_LEN_MIN;
            PH_FRAME: begin
                if (frame_index_reg == FRM_HEIGHT_HI) height_hold_next = {b, 8'h00};
                if (frame_index_reg == FRM_HEIGHT_LO) height_hold_next = {height_hold_reg[15:8], b};
                if (frame_index_reg == FRM_WIDTH_HI)  width_hold_next  = {b, 8'h00};
                if (frame_index_reg == FRM_WIDTH_LO)  width_hold_next  = {width_hold_reg[15:8], b};
                if (!emit_ok) frame_index_next = frame_index_reg + 4'd1;
            end
            default: begin
            end
        endcase
        // end of file returns everything to the start
        if (last) begin
            header_index_next   = 4'd0;
            skip_remaining_next = 16'd0;
            length_high_next    = 8'd0;
            frame_index_next    = 4'd0;
            height_hold_next    = 16'd0;
            width_hold_next     = 16'd0;
            result_given_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_MAGIC;
            header_index_reg   <= 4'd0;
            skip_remaining_reg <= 16'd0;
            length_high_reg    <= 8'd0;
            frame_index_reg    <= 4'd0;
            height_hold_reg    <= 16'd0;
            width_hold_reg     <= 16'd0;
            result_given_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg          <= phase_next;
            header_index_reg   <= header_index_next;
            skip_remaining_reg <= skip_remaining_next;
            length_high_reg    <= length_high_next;
            frame_index_reg    <= frame_index_next;
            height_hold_reg    <= height_hold_next;
            width_hold_reg     <= width_hold_next;
            result_given_reg   <= result_given_next;
        end
    end

    a_done_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |-> result_given_reg)
        else $error("done phase without a result");

    a_one_result_per_file: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |-> !result_given_reg)
        else $error("second result within one file");

    a_header_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_MAGIC |-> header_index_reg <= HDR_LAST_IDX)
        else $error("header index past the fixed header");

    a_result_clears_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && last |=> !result_given_reg && phase_reg == PH_MAGIC)
        else $error("state not cleared after last byte");

endmodule

// ===== hdl/jhdp_out_reg.sv =====
// result register holding one parsed header result for the output channel
module jhdp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  jhdp_pkg::result_t res,
    output logic              m_tvalid,
    input  logic              m_tready,
    output jhdp_pkg::result_t m_res
);
    import jhdp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ===== hdl/jfif_header_dimension_parser.sv =====
// top level of the jfif header dimension parser
//
// usage:
//   the slave side takes a jpeg file one byte per beat, s_tdata[7:0] the byte
//   and s_tlast high on the final byte of the file
//   the master side gives one result beat per file: ok with the sof0 width
//   and height, or a header error with both dimensions zero
//   bytes after the result are dropped until s_tlast, then the next file starts
// timing:
//   one byte per cycle sustained while the result side does not stall; a byte goes
//   through an input register, a single step of parse logic and a result register,
//   so m_tvalid rises from the result register once the byte that causes the result leaves the input register
// reset:
//   aresetn low at a rising clock edge drops any held beat and returns the parser to
//   the start of a file
// stall:
//   with m_tready low the result beat holds; bytes that give no result keep
//   flowing only while the result register is free, otherwise s_tready drops
//   after one more byte is held
module jfif_header_dimension_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status, image_width, image_height, zero pad
);
    import jhdp_pkg::*;

    beat_t   s_beat;
    beat_t   beat;
    logic    beat_valid;
    logic    proceed;
    logic    res_fire;
    result_t res;
    result_t m_res;

    assign s_beat.data_byte = s_tdata;
    assign s_beat.last_byte = s_tlast;

    // the held byte moves on once the result register can take a result
    assign proceed = beat_valid && (!m_tvalid || m_tready);

    jhdp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .take       (proceed),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    jhdp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (proceed),
        .beat     (beat),
        .res_fire (res_fire),
        .res      (res)
    );

    jhdp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_fire),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {7'd0, m_res};

    a_error_has_zero_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("error result with nonzero dimensions");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |-> !m_tvalid || m_tready)
        else $error("result register overwritten while full");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:33] == 7'd0)
        else $error("nonzero pad bits in result beat");

endmodule

// ===== bench/jhdp_dimension_check.sv =====
// checker for the jfif header dimension parser: predicts the per-file result and compares beats
module jhdp_dimension_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // status, image_width, image_height, zero pad
    output int          fail_count,
    output int          waiting_count,
    output int          ok_count,
    output int          err_count
);
    import jhdp_pkg::*;

    phase_t      phase;
    logic [3:0]  hdr_idx;
    logic [15:0] skip_left;
    logic [7:0]  len_hi;
    logic [3:0]  frm_idx;
    logic [15:0] height_acc;
    logic [15:0] width_acc;
    logic        file_reported;
    logic        step_fired;

    result_t     expected_dims[$];
    int          mismatches;
    int          seen_ok;
    int          seen_err;

    task automatic clear_parser();
        phase         = PH_MAGIC;
        hdr_idx       = '0;
        skip_left     = '0;
        len_hi        = '0;
        frm_idx       = '0;
        height_acc    = '0;
        width_acc     = '0;
        file_reported = 1'b0;
    endtask

    task automatic post_result(input logic st, input logic [15:0] w, input logic [15:0] h);
        result_t r;
        r.status       = st;
        r.image_width  = w;
        r.image_height = h;
        expected_dims.push_back(r);
        file_reported = 1'b1;
        step_fired    = 1'b1;
        phase         = PH_DONE;
    endtask

    task automatic parse_byte(input logic [7:0] d, input logic lst);
        int          k;
        logic        bad;
        logic [15:0] seg_len;
        step_fired = 1'b0;
        case (phase)
            PH_MAGIC: begin
                k   = hdr_idx;
                bad = 1'b0;
                if (hdr_idx < HDR_MAGIC_END) begin
                    bad = (d != SOI_APP0_WORD[8*k +: 8]);
                end else if (hdr_idx == HDR_LENHI_IDX) begin
                    len_hi = d;
                end else if (hdr_idx == HDR_LENLO_IDX) begin
                    seg_len   = {len_hi, d};
                    bad       = (seg_len < APP0_LEN_MIN);
                    skip_left = seg_len - APP0_LEN_MIN;
                end else begin
                    bad = (d != JFIF_WORD[8*(k - HDR_JFIF_IDX) +: 8]);
                end
                if (bad) begin
                    post_result(STATUS_ERR, 16'h0000, 16'h0000);
                end else if (hdr_idx == HDR_LAST_IDX) begin
                    if (skip_left == 16'h0000) phase = PH_MARKER;
                    else phase = PH_SKIP;
                end else begin
                    hdr_idx = hdr_idx + 4'd1;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'h0000) phase = PH_MARKER;
            end
            PH_MARKER: begin
                if (d != MARK_BYTE) post_result(STATUS_ERR, 16'h0000, 16'h0000);
                else phase = PH_ID;
            end
            PH_ID: begin
                if (d == SOF0_ID) begin
                    frm_idx = '0;
                    phase   = PH_FRAME;
                end else begin
                    phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                len_hi = d;
                phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seg_len = {len_hi, d};
                if (seg_len < SEG_LEN_MIN) begin
                    post_result(STATUS_ERR, 16'h0000, 16'h0000);
                end else begin
                    skip_left = seg_len - SEG_LEN_MIN;
                    if (skip_left == 16'h0000) phase = PH_MARKER;
                    else phase = PH_SKIP;
                end
            end
            PH_FRAME: begin
                case (frm_idx)
                    FRM_HEIGHT_HI: height_acc = {d, 8'h00};
                    FRM_HEIGHT_LO: height_acc = height_acc | {8'h00, d};
                    FRM_WIDTH_HI:  width_acc  = {d, 8'h00};
                    FRM_WIDTH_LO: begin
                        width_acc = width_acc | {8'h00, d};
                        post_result(STATUS_OK, width_acc, height_acc);
                    end
                    default: ;
                endcase
                if (!step_fired) frm_idx = frm_idx + 4'd1;
            end
            default: ;
        endcase
        if (lst) begin
            if (!step_fired && !file_reported) post_result(STATUS_ERR, 16'h0000, 16'h0000);
            clear_parser();
        end
    endtask

    task automatic check_result(input logic [39:0] beat);
        result_t want;
        if (expected_dims.size() == 0) begin
            $error("result beat %h with no file result pending", beat);
            mismatches++;
        end else begin
            want = expected_dims.pop_front();
            if (beat[0] != want.status) begin
                $error("status: expected %0d, got %0d", want.status, beat[0]);
                mismatches++;
            end
            if (beat[16:1] != want.image_width) begin
                $error("image_width: expected %0d, got %0d", want.image_width, beat[16:1]);
                mismatches++;
            end
            if (beat[32:17] != want.image_height) begin
                $error("image_height: expected %0d, got %0d", want.image_height, beat[32:17]);
                mismatches++;
            end
            if (beat[39:33] != 7'h00) begin
                $error("pad: expected 0, got %0h", beat[39:33]);
                mismatches++;
            end
        end
        if (beat[0] == STATUS_OK) seen_ok++;
        else seen_err++;
    endtask

    initial begin
        mismatches = 0;
        seen_ok    = 0;
        seen_err   = 0;
        clear_parser();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            expected_dims.delete();
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
        end
        fail_count    <= mismatches;
        waiting_count <= expected_dims.size();
        ok_count      <= seen_ok;
        err_count     <= seen_err;
    end

endmodule

// ===== bench/testbench.sv =====
// top of the jfif header dimension parser testbench: clock, reset, byte stimulus and verdict
module testbench;
    import jhdp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MIN_BYTES   = 850;
    localparam int MIN_FILES   = 20;
    localparam int CALM_BYTES  = 700;
    localparam int LONG_HOLD   = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // status, image_width, image_height, zero pad

    int   fail_count;
    int   waiting_count;
    int   ok_count;
    int   err_count;
    int   bytes_sent;
    int   files_sent;
    int   cycles;
    bit   tx_idle;
    bit   rx_idle;
    bit   long_hold_req;
    logic [7:0] file_bytes[$];

    jfif_header_dimension_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    jhdp_dimension_check dim_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .waiting_count (waiting_count),
        .ok_count      (ok_count),
        .err_count     (err_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stall bursts plus the long hold
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 15);
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic lst);
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // jfif file: header, app0 payload, other segments, sof0, trailing bytes; may be malformed
    task automatic build_jfif(input logic [15:0] app0_len, input int seg_count,
                              input bit short_seg, input logic [15:0] h,
                              input logic [15:0] w, input int trail);
        logic [7:0]  id;
        logic [15:0] slen;
        file_bytes.delete();
        for (int k = 0; k < 4; k++) file_bytes.push_back(SOI_APP0_WORD[8*k +: 8]);
        file_bytes.push_back(app0_len[15:8]);
        file_bytes.push_back(app0_len[7:0]);
        for (int k = 0; k < 4; k++) file_bytes.push_back(JFIF_WORD[8*k +: 8]);
        for (int i = 6; i < app0_len; i++) file_bytes.push_back(8'($urandom));
        for (int s = 0; s < seg_count; s++) begin
            id = 8'($urandom);
            while (id == SOF0_ID) id = 8'($urandom);
            if (short_seg && s == 0) slen = 16'($urandom_range(0, 1));
            else slen = 16'($urandom_range(2, 12));
            file_bytes.push_back(MARK_BYTE);
            file_bytes.push_back(id);
            file_bytes.push_back(slen[15:8]);
            file_bytes.push_back(slen[7:0]);
            for (int j = 2; j < slen; j++) file_bytes.push_back(8'($urandom));
        end
        file_bytes.push_back(MARK_BYTE);
        file_bytes.push_back(SOF0_ID);
        repeat (3) file_bytes.push_back(8'($urandom));
        file_bytes.push_back(h[15:8]);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
        repeat (trail) file_bytes.push_back(8'($urandom));
    endtask

    initial begin
        int kind;
        int cut;
        logic [15:0] app0_len;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        long_hold_req = 1'b0;
        bytes_sent    = 0;
        files_sent    = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // one-byte file, broken magic, then a minimal file ending on the width byte
        file_bytes.delete();
        file_bytes.push_back(8'h00);
        send_file();
        file_bytes.delete();
        file_bytes.push_back(MARK_BYTE);
        file_bytes.push_back(8'h00);
        send_file();
        build_jfif(16'd6, 0, 1'b0, 16'hFFFF, 16'h0000, 0);
        send_file();

        while (bytes_sent < MIN_BYTES || files_sent < MIN_FILES) begin
            tx_idle = (bytes_sent < CALM_BYTES);
            rx_idle = (bytes_sent < CALM_BYTES);
            if (files_sent == 5 || files_sent == 15) long_hold_req = 1'b1;
            if ($urandom_range(0, 15) == 0) app0_len = 16'($urandom_range(0, 5));
            else app0_len = 16'($urandom_range(6, 24));
            build_jfif(app0_len, $urandom_range(0, 3), $urandom_range(0, 15) == 0,
                       pick_dim(), pick_dim(), $urandom_range(0, 6));
            kind = $urandom_range(0, 19);
            if (kind >= 12 && kind <= 14) begin
                file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
            end else if (kind >= 15 && kind <= 17) begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end else if (kind >= 18) begin
                file_bytes.delete();
                repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom));
            end
            send_file();
        end

        // long app0 payload with a nonzero length high byte, sent back to back
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        build_jfif(16'h0104, 1, 1'b0, pick_dim(), pick_dim(), 2);
        send_file();

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (waiting_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d files in %0d bytes, including a long result stall", files_sent,
                 bytes_sent);
        $display("results seen: %0d with dimensions, %0d header errors", ok_count, err_count);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/jhdp_pkg.sv
hdl/jhdp_in_reg.sv
hdl/jhdp_parser.sv
hdl/jhdp_out_reg.sv
hdl/jfif_header_dimension_parser.sv
bench/jhdp_dimension_check.sv
bench/testbench.sv
